// ----- rtl/core/touch_key_press_qualifier_unit_macros.svh -----
// ----------------------------------------------------------------------------
// touch_key_press_qualifier_unit_macros
// Assertion macros for the touch key press qualifier; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef TOUCH_KEY_PRESS_QUALIFIER_UNIT_MACROS_SVH
`define TOUCH_KEY_PRESS_QUALIFIER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TKPQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tkpq assertion failed");
`define TKPQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tkpq assertion failed");
`else
`define TKPQ_ASSERT(label, clk, rstn, prop)
`define TKPQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/core/tkpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tkpq_pkg
// Types, codes and key decode shared by the touch key press qualifier.
// ----------------------------------------------------------------------------
package tkpq_pkg;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;

    localparam logic [2:0] KEY_NONE = 3'd0;
    localparam logic [2:0] KEY_1    = 3'd1;
    localparam logic [2:0] KEY_2    = 3'd2;
    localparam logic [2:0] KEY_3    = 3'd3;
    localparam logic [2:0] KEY_4    = 3'd4;

    localparam logic [7:0] RAW_KEY_1 = 8'h04;
    localparam logic [7:0] RAW_KEY_2 = 8'h02;
    localparam logic [7:0] RAW_KEY_3 = 8'h80;
    localparam logic [7:0] RAW_KEY_4 = 8'h01;

    localparam logic [1:0] CFG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [1:0] CFG_TICKS_PER_UNIT = 2'd1;
    localparam logic [1:0] CFG_HOLD_UNITS     = 2'd2;

    localparam logic [7:0] DEBOUNCE_TICKS_RST = 8'd5;
    localparam logic [7:0] TICKS_PER_UNIT_RST = 8'd100;
    localparam logic [3:0] HOLD_UNITS_RST     = 4'd3;

    typedef struct packed {
        logic       tick;
        logic [7:0] raw_key;
        logic       system_on;
        logic       timer_active;
    } in_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [2:0] key_id;
    } out_t;

    typedef struct packed {
        logic [7:0] debounce_ticks;
        logic [7:0] ticks_per_unit;
        logic [3:0] hold_units;
    } cfg_t;

    typedef struct packed {
        logic [2:0] last_key;
        logic       pressing;
        logic [7:0] tick_count;
        logic [3:0] unit_count;
        logic       long_latched;
    } state_t;

    function automatic logic [2:0] decode_key(input logic [7:0] raw);
        logic [2:0] k;
        case (raw)
            RAW_KEY_1: k = KEY_1;
            RAW_KEY_2: k = KEY_2;
            RAW_KEY_3: k = KEY_3;
            RAW_KEY_4: k = KEY_4;
            default:   k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/core/tkpq_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tkpq_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tkpq_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    output tkpq_pkg::cfg_t cfg
);

    tkpq_pkg::cfg_t cfg_reg;
    tkpq_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                tkpq_pkg::CFG_DEBOUNCE_TICKS: cfg_next.debounce_ticks = cfg_data;
                tkpq_pkg::CFG_TICKS_PER_UNIT: cfg_next.ticks_per_unit = cfg_data;
                tkpq_pkg::CFG_HOLD_UNITS:     cfg_next.hold_units = cfg_data[3:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= tkpq_pkg::DEBOUNCE_TICKS_RST;
            cfg_reg.ticks_per_unit <= tkpq_pkg::TICKS_PER_UNIT_RST;
            cfg_reg.hold_units     <= tkpq_pkg::HOLD_UNITS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/tkpq_in_stage.sv -----
// ----------------------------------------------------------------------------
// tkpq_in_stage
// Input request register with pass-through backpressure.
// ----------------------------------------------------------------------------
module tkpq_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tkpq_pkg::in_t s_data,
    output logic          q_valid,
    input  logic          q_ready,
    output tkpq_pkg::in_t q_data
);

    logic          valid_reg;
    logic          valid_next;
    tkpq_pkg::in_t data_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

// ----- rtl/core/tkpq_qualifier.sv -----
// ----------------------------------------------------------------------------
// tkpq_qualifier
// Key hold tracking, debounce / long press decision and result register.
// ----------------------------------------------------------------------------
`include "touch_key_press_qualifier_unit_macros.svh"

module tkpq_qualifier (
    input  logic           aclk,
    input  logic           aresetn,
    input  tkpq_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  tkpq_pkg::in_t  in_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tkpq_pkg::out_t m_data
);

    tkpq_pkg::state_t state_reg;
    tkpq_pkg::state_t state_next;
    tkpq_pkg::state_t st;
    tkpq_pkg::out_t   res;
    tkpq_pkg::out_t   out_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             adv;
    logic [2:0]       key;
    logic             any_evt;
    logic             long_evt;
    logic             no_key;

    assign in_ready = !out_valid_reg || m_ready;
    assign adv      = in_valid && in_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign key      = tkpq_pkg::decode_key(in_data.raw_key);
    assign any_evt  = adv && (res.event_res != tkpq_pkg::EV_NONE);
    assign long_evt = adv && (res.event_res == tkpq_pkg::EV_LONG);
    assign no_key   = (state_reg.last_key == tkpq_pkg::KEY_NONE);

    always_comb begin
        st  = state_reg;
        res = '{event_res: tkpq_pkg::EV_NONE, key_id: tkpq_pkg::KEY_NONE};
        if (in_data.tick) begin
            if (key != st.last_key) begin
                if (key == tkpq_pkg::KEY_NONE) begin
                    st.pressing = 1'b0;
                    if (st.last_key == tkpq_pkg::KEY_1) begin
                        if (!st.long_latched && (st.unit_count != 4'd0 ||
                            st.tick_count >= cfg.debounce_ticks)) begin
                            res.event_res = tkpq_pkg::EV_SHORT;
                            res.key_id    = tkpq_pkg::KEY_1;
                        end else if (st.long_latched) begin
                            st.long_latched = 1'b0;
                        end
                    end else if (st.last_key == tkpq_pkg::KEY_3) begin
                        st.long_latched = 1'b0;
                    end
                end else begin
                    st.pressing   = 1'b1;
                    st.tick_count = 8'd0;
                    st.unit_count = 4'd0;
                end
                st.last_key = key;
            end

            if (st.pressing) begin
                if (st.tick_count == cfg.debounce_ticks) begin
                    if (st.last_key == tkpq_pkg::KEY_3 && !in_data.system_on &&
                        !in_data.timer_active) begin
                        st.pressing = 1'b1;
                    end else if (st.last_key != tkpq_pkg::KEY_1) begin
                        st.pressing   = 1'b0;
                        res.event_res = tkpq_pkg::EV_SHORT;
                        res.key_id    = st.last_key;
                    end
                end else if (st.tick_count == cfg.ticks_per_unit) begin
                    st.unit_count = 4'(st.unit_count + 4'd1);
                    if (st.unit_count == cfg.hold_units) begin
                        st.long_latched = 1'b1;
                        st.pressing     = 1'b0;
                        res.event_res   = tkpq_pkg::EV_LONG;
                        res.key_id      = st.last_key;
                    end else begin
                        st.tick_count = 8'd0;
                    end
                end
                st.tick_count = 8'(st.tick_count + 8'd1);
            end
        end
    end

    always_comb begin
        state_next     = adv ? st : state_reg;
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= res;
        end
    end

    `TKPQ_ASSERT(a_long_latches, aclk, aresetn, long_evt |=> state_reg.long_latched)
    `TKPQ_ASSERT(a_event_has_key, aclk, aresetn, any_evt |-> res.key_id != tkpq_pkg::KEY_NONE)
    `TKPQ_ASSERT(a_idle_tick_holds, aclk, aresetn, adv && !in_data.tick |=> $stable(state_reg))
    `TKPQ_ASSERT(a_pressing_has_key, aclk, aresetn, state_reg.pressing |-> !no_key)
    `TKPQ_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !out_valid_reg)

endmodule

// ----- rtl/core/touch_key_press_qualifier_unit.sv -----
// Path: a request is held in the input register, then its result in the result register that drives m_valid.
// Throughput: one request per cycle while m_ready is not held low; each request gives exactly one result.
// The rate is set by the input register and the result register, each taking
// a new request whenever the stage after it is free or drained that cycle.
// Reset (aresetn low, synchronous): key tracking state cleared, both stages
// empty, configuration back to debounce 5, ticks per unit 100, hold units 3.
// ----------------------------------------------------------------------------
// touch_key_press_qualifier_unit
// Touch key debounce and long press qualifier, top level.
// ----------------------------------------------------------------------------
module touch_key_press_qualifier_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tkpq_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output tkpq_pkg::out_t  m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_data
);

    tkpq_pkg::cfg_t cfg;
    tkpq_pkg::in_t  q_data;
    logic           q_valid;
    logic           q_ready;

    tkpq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tkpq_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    tkpq_qualifier u_qual (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_data  (q_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
